// File: hw/rtl/pfa_pkg.sv
// Shared types and constants for the paged frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;
  localparam logic [1:0] KIND_CREATE    = 2'd0;
  localparam logic [1:0] KIND_ACCESS    = 2'd1;
  localparam logic [1:0] KIND_TERMINATE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_BAD_PAGE  = 3'd3;
  localparam logic [2:0] ST_BAD_COUNT = 3'd4;

  localparam logic [0:0] CFG_FRAMES_IN_USE = 1'd0;
  localparam logic [0:0] CFG_PROCESS_LIMIT = 1'd1;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
endpackage
`default_nettype wire

// File: hw/rtl/pfa_modsub.sv
// Iterative restoring reducer: 16-bit value modulo a small count, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module pfa_modsub #(
  parameter int unsigned NW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          go_i,
  input  wire logic [15:0]   num_i,
  input  wire logic [NW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      rem_o
);
  logic [15:0]   num_q;
  logic [NW:0]   rem_q;
  logic [4:0]    cnt_q;
  logic          run_q;
  logic [NW-1:0] den_q;
  logic [NW+1:0] trial;

  // One shift-and-subtract step per cycle.
  assign trial = {rem_q, num_q[15]} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[14:0], 1'b0};
      if (!trial[NW+1]) rem_q <= trial[NW:0];
      else rem_q <= {rem_q[NW-1:0], num_q[15]};
    end
  end

  assign rem_o = rem_q[NW-1:0];
endmodule
`default_nettype wire

// File: hw/rtl/paged_frame_allocator_random_evict.sv
// Top level of the paged frame allocator with random victim selection.
`timescale 1ns / 1ps
`default_nettype none
// One operation is taken when start_i is high and busy_o low; its single result
// beat appears for one cycle with done_o and cannot be stalled. busy_o stays high
// until the cycle before done_o, and a new operation may be taken in the done_o
// cycle. A create clears its page table one entry a cycle; a rejected create
// goes straight to its result. Access and terminate first scan the slots one a
// cycle. After the scan an access reads the page table entry and answers a hit or
// a bad page from it; on a fault it draws a victim frame in the modulo reducer,
// then evicts and maps. After the scan a terminate walks its page table one entry
// a cycle. Reset needs no memory pass: a page table is cleared when its process
// is created.
module paged_frame_allocator_random_evict #(
  parameter int unsigned FRAMES    = 64,
  parameter int unsigned MAX_PROCS = 8,
  parameter int unsigned MAX_PAGES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] proc_id_i,
  input  wire logic [6:0]  page_index_i,
  input  wire logic [6:0]  page_count_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [5:0]       frame_index_o,
  output logic             page_fault_o,
  output logic             evicted_o,
  output logic [15:0]      evicted_proc_id_o,
  output logic [5:0]       evicted_page_o,
  output logic [6:0]       freed_frames_o
);
  import pfa_pkg::*;

  localparam int unsigned SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned NW = $clog2(FRAMES + 1);
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_FIND = 4'd1, S_CLEAR = 4'd2, S_ACC_RD = 4'd3,
                         S_ACC_CHK = 4'd4, S_MOD = 4'd5, S_FRD = 4'd6, S_FEV = 4'd7,
                         S_TRM_RD = 4'd8, S_TRM_CHK = 4'd9, S_DONE = 4'd10,
                         S_ACC_WAIT = 4'd11, S_FMAP = 4'd12;

  logic [3:0]  state_q;
  logic [6:0]  fiu_q;
  logic [3:0]  plim_q;
  logic [15:0] lfsr_q;
  logic [MAX_PROCS-1:0] slot_live_q;
  logic [15:0] slot_id_q  [MAX_PROCS];
  logic [6:0]  slot_cnt_q [MAX_PROCS];
  logic [FRAMES-1:0] frame_used_q;

  // Page table and frame table memories. A page table entry holds a valid bit
  // above the frame number.
  logic [FW:0]   pmap_mem [2**(SW+PW)];
  logic [SW-1:0] fown_mem [FRAMES];
  logic [PW-1:0] fpg_mem  [FRAMES];
  logic [FW:0]   pmap_rd_q;
  logic [SW-1:0] fown_rd_q;
  logic [PW-1:0] fpg_rd_q;

  logic [1:0]  kind_q;
  logic [15:0] id_q;
  logic [6:0]  pidx_q;
  logic [6:0]  pcnt_q;
  logic [SW-1:0] slot_q;
  logic [SW:0]   scan_q;
  logic [CW-1:0] walk_q;
  logic [6:0]    freed_q;
  logic [FW-1:0] victim_q;

  logic [2:0]  st_q;
  logic [5:0]  frm_q;
  logic        flt_q, ev_q;
  logic [15:0] evid_q;
  logic [5:0]  evpg_q;

  // Free slot search and live count over the small slot table.
  logic [SW:0] live_cnt;
  logic [SW:0] free_slot;
  logic        have_free;
  always_comb begin
    live_cnt  = '0;
    free_slot = '0;
    have_free = 1'b0;
    for (int s = 0; s < MAX_PROCS; s++) begin
      if (slot_live_q[s]) live_cnt = live_cnt + 1'b1;
      else if (!have_free) begin
        have_free = 1'b1;
        free_slot = (SW+1)'(s);
      end
    end
  end

  logic [NW-1:0] nfr;
  always_comb begin
    if (fiu_q == 7'd0) nfr = NW'(1);
    else if (32'(fiu_q) > FRAMES) nfr = NW'(FRAMES);
    else nfr = NW'(fiu_q);
  end

  logic [15:0] lfsr_nx;
  assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

  logic          mod_go, mod_done;
  logic [NW-1:0] mod_rem;
  pfa_modsub #(.NW(NW)) u_mod (
    .clk_i, .rst_ni, .go_i(mod_go), .num_i(lfsr_nx), .den_i(nfr),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  // Page table read address: the walk index during terminate, else the page.
  logic             walk_rd;
  logic [SW+PW-1:0] pt_rd_addr;
  assign walk_rd    = (state_q == S_TRM_RD) || (state_q == S_TRM_CHK);
  assign pt_rd_addr = {slot_q, walk_rd ? walk_q[PW-1:0] : pidx_q[PW-1:0]};

  // Page table write port: clear on create, unmap the victim, map the new page.
  logic             pt_we;
  logic [SW+PW-1:0] pt_wr_addr;
  logic [FW:0]      pt_wr_data;
  always_comb begin
    pt_we      = 1'b0;
    pt_wr_addr = {slot_q, pidx_q[PW-1:0]};
    pt_wr_data = '0;
    case (state_q)
      S_CLEAR: begin
        pt_we      = 1'b1;
        pt_wr_addr = {slot_q, walk_q[PW-1:0]};
      end
      S_FEV: begin
        pt_we      = frame_used_q[victim_q];
        pt_wr_addr = {fown_rd_q, fpg_rd_q};
      end
      S_FMAP: begin
        pt_we      = 1'b1;
        pt_wr_data = {1'b1, victim_q};
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign mod_go = (state_q == S_ACC_CHK) && (32'(pidx_q) < 32'(slot_cnt_q[slot_q]))
                  && (32'(pidx_q) < MAX_PAGES) && !pmap_rd_q[FW];

  logic [SW-1:0] scan_s;
  assign scan_s = scan_q[SW-1:0];

  always_ff @(posedge clk_i) begin
    pmap_rd_q <= pmap_mem[pt_rd_addr];
    fown_rd_q <= fown_mem[victim_q];
    fpg_rd_q  <= fpg_mem[victim_q];
    if (pt_we) pmap_mem[pt_wr_addr] <= pt_wr_data;
    if (state_q == S_FEV) begin
      fown_mem[victim_q] <= slot_q;
      fpg_mem[victim_q]  <= pidx_q[PW-1:0];
    end
    if (state_q == S_IDLE && start_i) begin
      kind_q <= kind_i;
      id_q   <= proc_id_i;
      pidx_q <= page_index_i;
      pcnt_q <= page_count_i;
    end
    if (state_q == S_CLEAR && walk_q == '0) begin
      slot_id_q[slot_q]  <= id_q;
      slot_cnt_q[slot_q] <= pcnt_q;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fiu_q        <= 7'd64;
      plim_q       <= 4'd8;
      lfsr_q       <= 16'd1;
      slot_live_q  <= '0;
      frame_used_q <= '0;
      done_o       <= 1'b0;
      slot_q <= '0; scan_q <= '0; walk_q <= '0; freed_q <= '0; victim_q <= '0;
      st_q <= '0; frm_q <= '0; flt_q <= 1'b0; ev_q <= 1'b0; evid_q <= '0; evpg_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAMES_IN_USE) fiu_q <= cfg_data_i;
        else plim_q <= cfg_data_i[3:0];
      end
      case (state_q)
        S_IDLE: if (start_i) begin
          st_q <= ST_OK; frm_q <= '0; flt_q <= 1'b0; ev_q <= 1'b0;
          evid_q <= '0; evpg_q <= '0; freed_q <= '0; scan_q <= '0; walk_q <= '0;
          if (kind_i == KIND_CREATE) begin
            if (32'(live_cnt) >= 32'(plim_q) || !have_free) begin
              st_q <= ST_FULL; state_q <= S_DONE;
            end else if (page_count_i == 7'd0 || 32'(page_count_i) > MAX_PAGES) begin
              st_q <= ST_BAD_COUNT; state_q <= S_DONE;
            end else begin
              slot_q <= free_slot[SW-1:0];
              slot_live_q[free_slot[SW-1:0]] <= 1'b1;
              state_q <= S_CLEAR;
            end
          end else if (kind_i == KIND_ACCESS || kind_i == KIND_TERMINATE) begin
            state_q <= S_FIND;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_CLEAR: begin
          if (32'(walk_q) == MAX_PAGES - 1) state_q <= S_DONE;
          walk_q <= walk_q + 1'b1;
        end
        S_FIND: begin
          if (32'(scan_q) == MAX_PROCS) begin
            st_q <= ST_NOT_FOUND; state_q <= S_DONE;
          end else if (slot_live_q[scan_s] && slot_id_q[scan_s] == id_q) begin
            slot_q  <= scan_s;
            state_q <= (kind_q == KIND_ACCESS) ? S_ACC_RD : S_TRM_RD;
          end else scan_q <= scan_q + 1'b1;
        end
        S_ACC_RD: state_q <= S_ACC_WAIT;
        S_ACC_WAIT: state_q <= S_ACC_CHK;
        S_ACC_CHK: begin
          if (32'(pidx_q) >= 32'(slot_cnt_q[slot_q]) || 32'(pidx_q) >= MAX_PAGES) begin
            st_q <= ST_BAD_PAGE; state_q <= S_DONE;
          end else if (pmap_rd_q[FW]) begin
            frm_q <= 6'(pmap_rd_q[FW-1:0]); state_q <= S_DONE;
          end else begin
            lfsr_q <= lfsr_nx; state_q <= S_MOD;
          end
        end
        S_MOD: if (mod_done) begin
          victim_q <= FW'(mod_rem); state_q <= S_FRD;
        end
        S_FRD: state_q <= S_FEV;
        S_FEV: begin
          if (frame_used_q[victim_q]) begin
            ev_q   <= 1'b1;
            evid_q <= slot_id_q[fown_rd_q];
            evpg_q <= 6'(fpg_rd_q);
          end
          frame_used_q[victim_q] <= 1'b1;
          frm_q <= 6'(victim_q);
          flt_q <= 1'b1;
          state_q <= S_FMAP;
        end
        S_FMAP: state_q <= S_DONE;
        // Prime the walk with the first entry of the slot's page table.
        S_TRM_RD: begin
          walk_q  <= walk_q + 1'b1;
          state_q <= S_TRM_CHK;
        end
        // The entry read last cycle is checked while the next one is read.
        S_TRM_CHK: begin
          if (pmap_rd_q[FW]) begin
            frame_used_q[pmap_rd_q[FW-1:0]] <= 1'b0;
            freed_q <= freed_q + 1'b1;
          end
          if (32'(walk_q) == MAX_PAGES) begin
            slot_live_q[slot_q] <= 1'b0; state_q <= S_DONE;
          end else begin
            walk_q <= walk_q + 1'b1;
          end
        end
        S_DONE: begin
          done_o <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o          = st_q;
  assign frame_index_o     = frm_q;
  assign page_fault_o      = flt_q;
  assign evicted_o         = ev_q;
  assign evicted_proc_id_o = evid_q;
  assign evicted_page_o    = evpg_q;
  assign freed_frames_o    = freed_q;

  // A fault always reports an ok status.
  a_fault_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && page_fault_o |-> status_o == ST_OK) else $error("fault with bad status");
  // Eviction only happens on a fault.
  a_ev_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_o |-> page_fault_o) else $error("eviction without fault");
  // A result only follows a busy cycle.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result while idle");
  // The LFSR never reaches zero.
  a_lfsr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != 16'd0) else $error("lfsr stuck at zero");
endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the paged frame allocator with random victim selection.
`timescale 1ns / 1ps
module testbench;
  import pfa_pkg::*;

  localparam int unsigned NUM_FRAMES = 64;
  localparam int unsigned NUM_SLOTS  = 8;
  localparam int unsigned NUM_PAGES  = 64;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  frame;
    logic        fault;
    logic        evicted;
    logic [15:0] ev_id;
    logic [5:0]  ev_page;
    logic [6:0]  freed;
  } outcome_t;

  // One row of the directed table: an operation or a register write.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  kind;
    logic [15:0] pid;
    logic [6:0]  pidx;
    logic [6:0]  pcnt;
    int          typed_status;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  kind_i = '0;
  logic [15:0] proc_id_i = '0;
  logic [6:0]  page_index_i = '0;
  logic [6:0]  page_count_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;
  logic        busy_o, done_o, page_fault_o, evicted_o;
  logic [2:0]  status_o;
  logic [5:0]  frame_index_o, evicted_page_o;
  logic [15:0] evicted_proc_id_o;
  logic [6:0]  freed_frames_o;

  paged_frame_allocator_random_evict u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .kind_i, .proc_id_i, .page_index_i,
    .page_count_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o, .status_o,
    .frame_index_o, .page_fault_o, .evicted_o, .evicted_proc_id_o,
    .evicted_page_o, .freed_frames_o
  );

  // Shadow copy of the allocator state.
  bit          live_tab[NUM_SLOTS];
  logic [15:0] owner_id_tab[NUM_SLOTS];
  int          page_cnt_tab[NUM_SLOTS];
  int          map_tab[NUM_SLOTS][NUM_PAGES];
  bit          map_valid[NUM_SLOTS][NUM_PAGES];
  bit          frame_busy[NUM_FRAMES];
  int          frame_slot[NUM_FRAMES];
  int          frame_vpage[NUM_FRAMES];
  logic [15:0] victim_seed;
  int          frames_setting;
  int          limit_setting;

  outcome_t    pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Lowest live slot holding this id, or -1.
  function automatic int lookup_slot(logic [15:0] pid);
    for (int s = 0; s < NUM_SLOTS; s++)
      if (live_tab[s] && owner_id_tab[s] == pid) return s;
    return -1;
  endfunction

  // Apply one operation to the shadow state and queue its outcome.
  task automatic predict_outcome(logic [1:0] kind, logic [15:0] pid, logic [6:0] pidx,
                                 logic [6:0] pcnt, int typed_status);
    outcome_t r;
    int s, live, free_slot, n, v, os, op;
    r = '{status: ST_OK, frame: '0, fault: 1'b0, evicted: 1'b0, ev_id: '0,
          ev_page: '0, freed: '0};
    case (kind)
      KIND_CREATE: begin
        live = 0;
        free_slot = -1;
        for (s = 0; s < NUM_SLOTS; s++) begin
          if (live_tab[s]) live++;
          else if (free_slot < 0) free_slot = s;
        end
        if (live >= limit_setting || free_slot < 0) begin
          r.status = ST_FULL;
        end else if (pcnt == 0 || pcnt > NUM_PAGES) begin
          r.status = ST_BAD_COUNT;
        end else begin
          live_tab[free_slot] = 1'b1;
          owner_id_tab[free_slot] = pid;
          page_cnt_tab[free_slot] = pcnt;
          for (int i = 0; i < NUM_PAGES; i++) map_valid[free_slot][i] = 1'b0;
        end
      end
      KIND_ACCESS: begin
        s = lookup_slot(pid);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (pidx >= page_cnt_tab[s] || pidx >= NUM_PAGES) begin
          r.status = ST_BAD_PAGE;
        end else if (map_valid[s][pidx]) begin
          r.frame = map_tab[s][pidx];
        end else begin
          n = frames_setting == 0 ? 1 : (frames_setting > NUM_FRAMES ? NUM_FRAMES
                                                                     : frames_setting);
          // Galois step: shift right, fold the taps in when a one falls out.
          if (victim_seed[0]) victim_seed = (victim_seed >> 1) ^ LFSR_TAPS;
          else victim_seed = victim_seed >> 1;
          v = victim_seed % n;
          if (frame_busy[v]) begin
            os = frame_slot[v];
            op = frame_vpage[v];
            r.evicted = 1'b1;
            r.ev_id = owner_id_tab[os];
            r.ev_page = op;
            map_valid[os][op] = 1'b0;
          end
          frame_busy[v] = 1'b1;
          frame_slot[v] = s;
          frame_vpage[v] = pidx;
          map_tab[s][pidx] = v;
          map_valid[s][pidx] = 1'b1;
          r.frame = v;
          r.fault = 1'b1;
        end
      end
      KIND_TERMINATE: begin
        s = lookup_slot(pid);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < NUM_PAGES; i++)
            if (map_valid[s][i]) begin
              frame_busy[map_tab[s][i]] = 1'b0;
              map_valid[s][i] = 1'b0;
              r.freed++;
            end
          live_tab[s] = 1'b0;
        end
      end
      default: ;
    endcase
    if (typed_status >= 0) r.status = typed_status;
    pending_results.push_back(r);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Each result beat is checked against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing outstanding, status %0d", $time, status_o);
      end else begin
        e = pending_results.pop_front();
        compare_field("status", 32'(e.status), 32'(status_o));
        compare_field("frame_index", 32'(e.frame), 32'(frame_index_o));
        compare_field("page_fault", 32'(e.fault), 32'(page_fault_o));
        compare_field("evicted", 32'(e.evicted), 32'(evicted_o));
        compare_field("evicted_proc_id", 32'(e.ev_id), 32'(evicted_proc_id_o));
        compare_field("evicted_page", 32'(e.ev_page), 32'(evicted_page_o));
        compare_field("freed_frames", 32'(e.freed), 32'(freed_frames_o));
      end
    end
  end

  // Wait until every outstanding result has come back, plus a short margin.
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [6:0] data);
    @(negedge clk_i);
    start_i = 1'b0;
    drain_results();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_FRAMES_IN_USE) frames_setting = data;
    else limit_setting = data[3:0];
  endtask

  // Present one operation beat and hold it until the block takes it.
  task automatic issue_op(logic [1:0] kind, logic [15:0] pid, logic [6:0] pidx,
                          logic [6:0] pcnt, int typed_status);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    kind_i = kind;
    proc_id_i = pid;
    page_index_i = pidx;
    page_count_i = pcnt;
    do @(posedge clk_i); while (busy_o);
    predict_outcome(kind, pid, pidx, pcnt, typed_status);
  endtask

  // Draw an id: mostly from a small pool so operations find live processes.
  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(0, 9));
    if (r < 90) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic random_op();
    logic [15:0] pid;
    logic [6:0]  pidx, pcnt;
    logic [1:0]  kind;
    int r, s;
    pid = pick_id();
    r = $urandom_range(0, 99);
    kind = r < 12 ? KIND_CREATE : r < 88 ? KIND_ACCESS : r < 97 ? KIND_TERMINATE
                                                              : KIND_UNUSED;
    pcnt = $urandom_range(0, 99) < 90 ? 7'($urandom_range(1, 16))
                                      : 7'($urandom_range(0, 127));
    s = lookup_slot(pid);
    if (s >= 0 && $urandom_range(0, 99) < 90) pidx = 7'($urandom_range(0, page_cnt_tab[s] - 1));
    else pidx = 7'($urandom_range(0, 127));
    issue_op(kind, pid, pidx, pcnt, -1);
  endtask

  row_t directed_rows[] = '{
    '{0, KIND_ACCESS,    16'd5,    7'd0,   7'd0,   ST_NOT_FOUND},
    '{0, KIND_TERMINATE, 16'd5,    7'd0,   7'd0,   ST_NOT_FOUND},
    '{0, KIND_CREATE,    16'hFFFF, 7'd0,   7'd0,   ST_BAD_COUNT},
    '{0, KIND_CREATE,    16'hFFFF, 7'd0,   7'd65,  ST_BAD_COUNT},
    '{0, KIND_CREATE,    16'hFFFF, 7'd0,   7'd127, ST_BAD_COUNT},
    '{0, KIND_CREATE,    16'hFFFF, 7'd0,   7'd64,  ST_OK},
    '{0, KIND_ACCESS,    16'hFFFF, 7'd63,  7'd0,   -1},
    '{0, KIND_ACCESS,    16'hFFFF, 7'd63,  7'd0,   -1},
    '{0, KIND_ACCESS,    16'hFFFF, 7'd64,  7'd0,   ST_BAD_PAGE},
    '{0, KIND_ACCESS,    16'hFFFF, 7'd127, 7'd127, ST_BAD_PAGE},
    '{0, KIND_CREATE,    16'd0,    7'd0,   7'd1,   ST_OK},
    '{0, KIND_ACCESS,    16'd0,    7'd1,   7'd0,   ST_BAD_PAGE},
    '{0, KIND_ACCESS,    16'd0,    7'd0,   7'd0,   -1},
    // Duplicate id: lookups keep hitting the lower slot until it goes away.
    '{0, KIND_CREATE,    16'd0,    7'd0,   7'd2,   ST_OK},
    '{0, KIND_ACCESS,    16'd0,    7'd1,   7'd0,   ST_BAD_PAGE},
    '{0, KIND_UNUSED,    16'hFFFF, 7'd127, 7'd127, ST_OK},
    '{0, KIND_TERMINATE, 16'd0,    7'd0,   7'd0,   ST_OK},
    '{0, KIND_ACCESS,    16'd0,    7'd1,   7'd0,   -1},
    '{0, KIND_TERMINATE, 16'hFFFF, 7'd0,   7'd0,   ST_OK},
    // A zero process limit refuses every create.
    '{1, CFG_PROCESS_LIMIT, 16'd0, 7'd0,   7'd0,   -1},
    '{0, KIND_CREATE,    16'd7,    7'd0,   7'd4,   ST_FULL},
    '{1, CFG_PROCESS_LIMIT, 16'd0, 7'd0,   7'd2,   -1},
    '{0, KIND_CREATE,    16'd9,    7'd0,   7'd4,   ST_OK},
    '{0, KIND_CREATE,    16'd10,   7'd0,   7'd4,   ST_FULL},
    // Zero frames in use behaves as one frame.
    '{1, CFG_FRAMES_IN_USE, 16'd0, 7'd0,   7'd0,   -1},
    '{0, KIND_ACCESS,    16'd9,    7'd3,   7'd0,   -1},
    '{0, KIND_ACCESS,    16'd0,    7'd0,   7'd0,   -1}
  };

  // Register settings of the random phases: frames in use, process limit.
  int phase_frames[] = '{64, 1, 127, 4, 17, 64};
  int phase_limit[]  = '{8, 1, 15, 3, 8, 2};

  initial begin
    frames_setting = 64;
    limit_setting = 8;
    victim_seed = 16'd1;
    for (int s = 0; s < NUM_SLOTS; s++) live_tab[s] = 1'b0;
    for (int f = 0; f < NUM_FRAMES; f++) frame_busy[f] = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_reg(directed_rows[i].kind[0], directed_rows[i].pcnt);
      else
        issue_op(directed_rows[i].kind, directed_rows[i].pid, directed_rows[i].pidx,
                 directed_rows[i].pcnt, directed_rows[i].typed_status);
    end

    // Random phases; the sender idles rarely, then often, then never.
    for (int p = 0; p < 6; p++) begin
      @(negedge clk_i);
      start_i = 1'b0;
      write_reg(CFG_FRAMES_IN_USE, 7'(phase_frames[p]));
      write_reg(CFG_PROCESS_LIMIT, p == 2 ? 7'h7F : 7'(phase_limit[p]));
      idle_pct = p < 2 ? 6 : (p < 4 ? 78 : 0);
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) random_op();
    end

    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
